>>> rtl/core/lzrle_pkg.sv
// Shared constants and types of the LZ/RLE byte decoder.
`default_nettype none

package lzrle_pkg;

   localparam int HIST_DEPTH = 8192;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);

   typedef logic [1:0] status_type;

   localparam status_type ST_DATA = 2'd0;
   localparam status_type ST_END  = 2'd1;
   localparam status_type ST_FULL = 2'd2;
   localparam status_type ST_BUSY = 2'd3;

   localparam logic [31:0] OUTPUT_LENGTH_RESET = 32'd1024;

endpackage

`default_nettype wire

>>> rtl/core/lzrle_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module lzrle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/lz_rle_byte_decoder.sv
// Top level of the byte-wise LZ/RLE stream decoder with its history memory.
`default_nettype none

// The decoder takes one transaction per clock cycle on the request side: a
// compressed byte (tuser 0) or a pull of the next pending fill or copy byte
// (tuser 1). A result passes through the s1 register and then the response
// register. While a result waits on the response side, requests keep flowing
// until a second result is ready; the request side then stalls until the
// waiting response is taken.
// Every decoded byte is written to an 8192-entry history memory; a copy byte
// costs one history read at acceptance and one write when its result moves to
// the response register, with the written byte forwarded to a read of the same
// entry in that cycle. History entries that were never written read as zero by
// comparing against the write pointer, so no clearing pass follows reset. The
// output length register may be written on the csr channel while the decoder
// is idle.
module lz_rle_byte_decoder
   import lzrle_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tuser,   // [0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast,
   output logic      [1:0]  rsp_tuser,   // [1:0] status
   input  wire logic        csr_tvalid,
   output logic             csr_tready,
   input  wire logic [31:0] csr_tdata    // [31:0] output_length
);

   localparam logic [3:0] PH_CMD       = 4'd0;
   localparam logic [3:0] PH_LIT_LEN   = 4'd1;
   localparam logic [3:0] PH_LIT_DATA  = 4'd2;
   localparam logic [3:0] PH_FILL_LEN  = 4'd3;
   localparam logic [3:0] PH_FILL_VAL  = 4'd4;
   localparam logic [3:0] PH_FILL_RUN  = 4'd5;
   localparam logic [3:0] PH_POS_RUN   = 4'd6;
   localparam logic [3:0] PH_POS_COUNT = 4'd7;
   localparam logic [3:0] PH_COUNT     = 4'd8;
   localparam logic [3:0] PH_COPY_RUN  = 4'd9;

   localparam logic       FUNC_PULL = 1'b1;

   localparam logic [7:0] CMD_END        = 8'hFF;
   localparam logic [1:0] M_LITERAL      = 2'd0;
   localparam logic [1:0] M_FILL         = 2'd1;
   localparam logic [1:0] M_COPY         = 2'd2;
   localparam logic [1:0] SUB_SHORT      = 2'd0;
   localparam logic [1:0] SUB_COUNTED    = 2'd1;
   localparam logic [1:0] SUB_THREE      = 2'd2;
   localparam logic [7:0] LIT_LONG_BIAS  = 8'h21;
   localparam logic [7:0] FILL_LONG_BIAS = 8'h23;
   localparam logic [7:0] COPY_DIST_BIAS = 8'h03;

   localparam int SRC_W = HIST_AW + 2;

   logic [3:0]         phase_ff, phase_in;
   logic [13:0]        remaining_ff, remaining_in;
   logic [12:0]        distance_ff, distance_in;
   logic [7:0]         fill_value_ff, fill_value_in;
   logic [HIST_AW-1:0] write_index_ff, write_index_in;
   logic               hist_wrapped_ff, hist_wrapped_in;
   logic [31:0]        produced_ff, produced_in;
   logic               finished_ff, finished_in;
   logic [31:0]        output_length_ff;

   logic               s1_valid_ff;
   logic               s1_use_ram_ff, s1_use_ram_in;
   logic [7:0]         s1_byte_ff, s1_byte_in;
   logic               s1_last_ff, s1_last_in;
   status_type         s1_status_ff, s1_status_in;
   logic               s1_wr_ff, s1_wr_in;
   logic [HIST_AW-1:0] s1_wr_addr_ff;

   logic               rsp_valid_ff;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_last_ff;
   status_type         rsp_status_ff;

   logic               accept;
   logic               s1_go;
   logic [7:0]         s1_data;
   logic [7:0]         ram_rd_data;
   logic               ram_rd_en;
   logic [SRC_W-1:0]   src_sum;
   logic [SRC_W-1:0]   src_adj;
   logic [HIST_AW-1:0] src_addr;
   logic               src_written;
   logic               fwd_hit;
   logic               is_full;
   logic               res_valid;
   logic               do_emit;
   logic               emit_copy;
   logic [7:0]         emit_val;

   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;
   assign s1_data    = s1_use_ram_ff ? ram_rd_data : s1_byte_ff;
   assign is_full    = produced_ff >= output_length_ff;

   assign src_sum     = SRC_W'(write_index_ff) + SRC_W'(HIST_DEPTH) - SRC_W'(distance_ff);
   assign src_adj     = (src_sum >= SRC_W'(HIST_DEPTH)) ? src_sum - SRC_W'(HIST_DEPTH) : src_sum;
   assign src_addr    = src_adj[HIST_AW-1:0];
   assign src_written = hist_wrapped_ff || (src_addr < write_index_ff);
   assign fwd_hit     = s1_valid_ff && s1_wr_ff && (s1_wr_addr_ff == src_addr);
   assign ram_rd_en   = accept && (req_tuser == FUNC_PULL) && (phase_ff == PH_COPY_RUN);

   always_comb begin
      phase_in        = phase_ff;
      remaining_in    = remaining_ff;
      distance_in     = distance_ff;
      fill_value_in   = fill_value_ff;
      write_index_in  = write_index_ff;
      hist_wrapped_in = hist_wrapped_ff;
      produced_in     = produced_ff;
      finished_in     = finished_ff;
      res_valid       = 1'b0;
      s1_use_ram_in   = 1'b0;
      s1_byte_in      = 8'd0;
      s1_last_in      = 1'b0;
      s1_status_in    = ST_DATA;
      s1_wr_in        = 1'b0;
      do_emit         = 1'b0;
      emit_copy       = 1'b0;
      emit_val        = fill_value_ff;
      if (accept) begin
         if (req_tuser == FUNC_PULL) begin
            if (phase_ff == PH_FILL_RUN) begin
               do_emit = 1'b1;
            end else if (phase_ff == PH_COPY_RUN) begin
               do_emit   = 1'b1;
               emit_copy = 1'b1;
            end
         end else if (finished_ff) begin
            res_valid    = 1'b1;
            s1_status_in = ST_END;
         end else begin
            case (phase_ff)
               PH_CMD: begin
                  if (req_tdata == CMD_END) begin
                     finished_in  = 1'b1;
                     res_valid    = 1'b1;
                     s1_status_in = ST_END;
                  end else if (is_full) begin
                     finished_in  = 1'b1;
                     res_valid    = 1'b1;
                     s1_status_in = ST_FULL;
                  end else begin
                     case (req_tdata[7:6])
                        M_LITERAL: begin
                           if (req_tdata[5]) begin
                              remaining_in = {1'b0, req_tdata[4:0], LIT_LONG_BIAS};
                              phase_in     = PH_LIT_LEN;
                           end else begin
                              remaining_in = 14'(req_tdata[4:0]) + 14'd1;
                              phase_in     = PH_LIT_DATA;
                           end
                        end
                        M_FILL: begin
                           if (req_tdata[5]) begin
                              remaining_in = {1'b0, req_tdata[4:0], FILL_LONG_BIAS};
                              phase_in     = PH_FILL_LEN;
                           end else begin
                              remaining_in = 14'(req_tdata[4:0]) + 14'd3;
                              phase_in     = PH_FILL_VAL;
                           end
                        end
                        M_COPY: begin
                           case (req_tdata[5:4])
                              SUB_SHORT: begin
                                 remaining_in = 14'(req_tdata[3:0]) + 14'd2;
                                 distance_in  = 13'd2;
                                 phase_in     = PH_POS_RUN;
                              end
                              SUB_COUNTED: begin
                                 distance_in = {1'b0, req_tdata[3:0], COPY_DIST_BIAS};
                                 phase_in    = PH_POS_COUNT;
                              end
                              SUB_THREE: begin
                                 distance_in  = {1'b0, req_tdata[3:0], COPY_DIST_BIAS};
                                 remaining_in = 14'd3;
                                 phase_in     = PH_POS_RUN;
                              end
                              default: begin
                                 distance_in  = {1'b0, req_tdata[3:0], COPY_DIST_BIAS};
                                 remaining_in = 14'd4;
                                 phase_in     = PH_POS_RUN;
                              end
                           endcase
                        end
                        default: begin
                           if (req_tdata[5]) begin
                              distance_in  = 13'(req_tdata[4:0]) + 13'd2;
                              remaining_in = 14'd2;
                           end else begin
                              distance_in  = 13'(req_tdata[4:0]) + 13'd1;
                              remaining_in = 14'd1;
                           end
                           phase_in = PH_COPY_RUN;
                        end
                     endcase
                  end
               end
               PH_LIT_LEN: begin
                  remaining_in = remaining_ff + 14'(req_tdata);
                  phase_in     = PH_LIT_DATA;
               end
               PH_LIT_DATA: begin
                  do_emit  = 1'b1;
                  emit_val = req_tdata;
               end
               PH_FILL_LEN: begin
                  remaining_in = remaining_ff + 14'(req_tdata);
                  phase_in     = PH_FILL_VAL;
               end
               PH_FILL_VAL: begin
                  fill_value_in = req_tdata;
                  phase_in      = PH_FILL_RUN;
               end
               PH_POS_RUN: begin
                  distance_in = distance_ff + 13'(req_tdata);
                  phase_in    = PH_COPY_RUN;
               end
               PH_POS_COUNT: begin
                  distance_in = distance_ff + 13'(req_tdata);
                  phase_in    = PH_COUNT;
               end
               PH_COUNT: begin
                  remaining_in = 14'(req_tdata) + 14'd4;
                  phase_in     = PH_COPY_RUN;
               end
               default: begin
                  res_valid    = 1'b1;
                  s1_status_in = ST_BUSY;
               end
            endcase
         end
         if (do_emit) begin
            res_valid    = 1'b1;
            remaining_in = remaining_ff - 14'd1;
            s1_last_in   = (remaining_in == 14'd0);
            if (s1_last_in) begin
               phase_in = PH_CMD;
            end
            if (is_full) begin
               s1_status_in = ST_FULL;
            end else begin
               s1_wr_in    = 1'b1;
               produced_in = produced_ff + 32'd1;
               if (write_index_ff == HIST_AW'(HIST_DEPTH - 1)) begin
                  write_index_in  = '0;
                  hist_wrapped_in = 1'b1;
               end else begin
                  write_index_in = write_index_ff + HIST_AW'(1);
               end
               if (!emit_copy) begin
                  s1_byte_in = emit_val;
               end else if (fwd_hit) begin
                  s1_byte_in = s1_data;
               end else if (src_written) begin
                  s1_use_ram_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_CMD;
         remaining_ff     <= '0;
         distance_ff      <= '0;
         fill_value_ff    <= '0;
         write_index_ff   <= '0;
         hist_wrapped_ff  <= 1'b0;
         produced_ff      <= '0;
         finished_ff      <= 1'b0;
         output_length_ff <= OUTPUT_LENGTH_RESET;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         remaining_ff    <= remaining_in;
         distance_ff     <= distance_in;
         fill_value_ff   <= fill_value_in;
         write_index_ff  <= write_index_in;
         hist_wrapped_ff <= hist_wrapped_in;
         produced_ff     <= produced_in;
         finished_ff     <= finished_in;
         if (csr_tvalid) begin
            output_length_ff <= csr_tdata;
         end
         if (accept) begin
            s1_valid_ff <= res_valid;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_use_ram_ff <= s1_use_ram_in;
         s1_byte_ff    <= s1_byte_in;
         s1_last_ff    <= s1_last_in;
         s1_status_ff  <= s1_status_in;
         s1_wr_ff      <= s1_wr_in;
         s1_wr_addr_ff <= write_index_ff;
      end
      if (s1_go) begin
         rsp_byte_ff   <= s1_data;
         rsp_last_ff   <= s1_last_ff;
         rsp_status_ff <= s1_status_ff;
      end
   end

   lzrle_ram #(
      .WIDTH (8),
      .DEPTH (HIST_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (s1_go && s1_wr_ff),
      .wr_addr (s1_wr_addr_ff),
      .wr_data (s1_data),
      .rd_en   (ram_rd_en),
      .rd_addr (src_addr),
      .rd_data (ram_rd_data)
   );

   assign csr_tready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

>>> rtl/core/lzrle_checker.sv
// Port-level assertions for the LZ/RLE byte decoder and their bind statement.
`default_nettype none

module lzrle_checker
   import lzrle_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic [1:0]  rsp_tuser
);

   // A result never shows up in the cycle right after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // Only data transactions carry a nonzero byte.
   a_status_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_DATA)) |-> (rsp_tdata == 8'd0))
      else $error("nonzero byte on a status transaction");

   // End-marker and busy transactions never close a command.
   a_status_no_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tuser == ST_END) || (rsp_tuser == ST_BUSY))) |-> !rsp_tlast)
      else $error("last flag on an end or busy transaction");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("response changed while stalled");

endmodule

bind lz_rle_byte_decoder lzrle_checker u_lzrle_checker (.*);

`default_nettype wire
